FILE: src/lkb_pkg.sv
// Shared types and constants of the luma keyed blend core.
`default_nettype none
package lkb_pkg;

    localparam int unsigned PIX_W     = 32;
    localparam int unsigned CH_W      = 8;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned FRAC_W    = 16;

    localparam logic [FRAC_W-1:0] FULL_SCALE = 16'hFF00;

    localparam logic [6:0] W_RED   = 7'd90;
    localparam logic [6:0] W_GREEN = 7'd115;
    localparam logic [6:0] W_BLUE  = 7'd51;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_START = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_END   = 8'd1;

    localparam logic [CH_W-1:0] START_RST = 8'd120;
    localparam logic [CH_W-1:0] END_RST   = 8'd132;

    typedef logic [PIX_W-1:0]  t_pixel;
    typedef logic [CH_W-1:0]   t_chan;
    typedef logic [FRAC_W-1:0] t_frac;

    typedef struct packed {
        t_chan start;
        t_chan stop;
    } t_thresh;

    typedef struct packed {
        logic valid;
        logic pass_a;
        logic pass_b;
    } t_key_ctl;

endpackage
`default_nettype wire

FILE: src/luma_keyed_blend_core.sv
// Top level of the luma keyed blend core: config registers and pixel pipeline.
//
// Pixel channel: drive i_start with the A, B and mask words; the beat is taken
// at a rising edge where i_start is high and o_busy is low. One pixel per clock
// is accepted back to back while o_busy stays low.
// Result: o_out_pixel is valid for one cycle while o_out_valid is high, once
// its input has passed registers r1 to r4. The receiver cannot stall, so the
// pipeline never holds; results leave in input order, one per accepted beat.
// Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data.
// Index 0 sets the start threshold, index 1 the end threshold; other indexes
// are dropped. Write only while no pixel is in flight.
// Each config write, and reset, starts a serial division of the full scale by
// the threshold range; o_busy stays high until the last quotient bit is in.
// Reset: synchronous, active low; thresholds return to 120 and 132 and the
// pipeline empties.
`default_nettype none
module luma_keyed_blend_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire lkb_pkg::t_pixel                   i_source_a_pixel,
    input  wire lkb_pkg::t_pixel                   i_source_b_pixel,
    input  wire lkb_pkg::t_pixel                   i_mask_pixel,
    output logic                                   o_out_valid,
    output lkb_pkg::t_pixel                        o_out_pixel,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [lkb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire lkb_pkg::t_chan                    i_cfg_data
);
    import lkb_pkg::*;

    t_chan     r_start;
    t_chan     r_stop;

    logic      n_cfg_wr;
    logic      n_accept;
    t_thresh   n_thresh;
    t_frac     n_mult;
    t_key_ctl  n_key_ctl;
    t_frac     n_alpha;
    t_pixel    n_key_a;
    t_pixel    n_key_b;

    assign o_cfg_ready = 1'b1;
    assign n_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign n_accept    = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_RST;
            r_stop  <= END_RST;
        end else if (n_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_IDX_START: r_start <= i_cfg_data;
                CFG_IDX_END:   r_stop  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_thresh.start = r_start;
        n_thresh.stop  = (r_stop < r_start) ? r_start : r_stop;
    end

    lkb_recip u_recip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (n_cfg_wr),
        .i_thresh  (n_thresh),
        .o_busy    (o_busy),
        .o_mult    (n_mult)
    );

    lkb_key u_key (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (n_accept),
        .i_a      (i_source_a_pixel),
        .i_b      (i_source_b_pixel),
        .i_mask   (i_mask_pixel),
        .i_thresh (n_thresh),
        .i_mult   (n_mult),
        .o_ctl    (n_key_ctl),
        .o_alpha  (n_alpha),
        .o_a      (n_key_a),
        .o_b      (n_key_b)
    );

    lkb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (n_key_ctl),
        .i_alpha (n_alpha),
        .i_a     (n_key_a),
        .i_b     (n_key_b),
        .o_valid (o_out_valid),
        .o_pixel (o_out_pixel)
    );

endmodule
`default_nettype wire

FILE: src/lkb_recip.sv
// Serial restoring divider producing the alpha ramp slope from the thresholds.
`default_nettype none
module lkb_recip (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_restart,
    input  wire lkb_pkg::t_thresh i_thresh,
    output logic                 o_busy,
    output lkb_pkg::t_frac       o_mult
);
    import lkb_pkg::*;

    logic        r_run;
    logic [3:0]  r_cnt;
    t_chan       r_rem;
    t_frac       r_quo;

    t_chan       n_range;
    t_chan       n_diff;
    logic [8:0]  n_shift;
    logic        n_bit;
    t_chan       n_rem;

    always_comb begin
        n_diff  = i_thresh.stop - i_thresh.start;
        n_range = (n_diff == '0) ? t_chan'(1) : n_diff;
        n_shift = {r_rem, FULL_SCALE[r_cnt]};
        n_bit   = (n_shift >= {1'b0, n_range});
        n_rem   = n_bit ? t_chan'(n_shift - {1'b0, n_range}) : n_shift[CH_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_run <= 1'b1;
            r_cnt <= 4'd15;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[FRAC_W-2:0], n_bit};
            r_cnt <= r_cnt - 4'd1;
            if (r_cnt == 4'd0) begin
                r_run <= 1'b0;
            end
        end
    end

    assign o_busy = r_run;
    assign o_mult = r_quo;

endmodule
`default_nettype wire

FILE: src/lkb_key.sv
// Luma and key stages: mask luma, threshold compare and alpha ramp.
`default_nettype none
module lkb_key (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire lkb_pkg::t_pixel  i_a,
    input  wire lkb_pkg::t_pixel  i_b,
    input  wire lkb_pkg::t_pixel  i_mask,
    input  wire lkb_pkg::t_thresh i_thresh,
    input  wire lkb_pkg::t_frac   i_mult,
    output lkb_pkg::t_key_ctl     o_ctl,
    output lkb_pkg::t_frac        o_alpha,
    output lkb_pkg::t_pixel       o_a,
    output lkb_pkg::t_pixel       o_b
);
    import lkb_pkg::*;

    logic       r1_valid;
    t_chan      r1_luma;
    t_pixel     r1_a;
    t_pixel     r1_b;

    t_key_ctl   r2_ctl;
    t_frac      r2_alpha;
    t_pixel     r2_a;
    t_pixel     r2_b;

    logic [15:0] n_luma_sum;
    t_chan       n_diff;
    logic [23:0] n_alpha;
    t_key_ctl    n_ctl;

    always_comb begin
        n_luma_sum = 16'(i_mask[23:16] * W_RED)
                   + 16'(i_mask[15:8]  * W_GREEN)
                   + 16'(i_mask[7:0]   * W_BLUE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_luma <= n_luma_sum[15:8];
        r1_a    <= i_a;
        r1_b    <= i_b;
    end

    always_comb begin
        n_diff       = r1_luma - i_thresh.start;
        n_alpha      = 24'(n_diff * i_mult);
        n_ctl.valid  = r1_valid;
        n_ctl.pass_b = (r1_luma < i_thresh.start);
        n_ctl.pass_a = !n_ctl.pass_b && (r1_luma >= i_thresh.stop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else begin
            r2_ctl <= n_ctl;
        end
        r2_alpha <= n_alpha[FRAC_W-1:0];
        r2_a     <= r1_a;
        r2_b     <= r1_b;
    end

    assign o_ctl   = r2_ctl;
    assign o_alpha = r2_alpha;
    assign o_a     = r2_a;
    assign o_b     = r2_b;

endmodule
`default_nettype wire

FILE: src/lkb_mix.sv
// Mix stages: per channel weighted products, sum and output select.
`default_nettype none
module lkb_mix (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lkb_pkg::t_key_ctl i_ctl,
    input  wire lkb_pkg::t_frac   i_alpha,
    input  wire lkb_pkg::t_pixel  i_a,
    input  wire lkb_pkg::t_pixel  i_b,
    output logic                  o_valid,
    output lkb_pkg::t_pixel       o_pixel
);
    import lkb_pkg::*;

    t_key_ctl    r3_ctl;
    logic [23:0] r3_pa [3];
    logic [23:0] r3_pb [3];
    t_pixel      r3_a;
    t_pixel      r3_b;

    logic        r4_valid;
    t_pixel      r4_pixel;

    t_frac       n_beta;
    logic [23:0] n_pa [3];
    logic [23:0] n_pb [3];
    logic [24:0] n_sum;
    t_pixel      n_blend;
    t_pixel      n_pixel;

    always_comb begin
        n_beta = FULL_SCALE - i_alpha;
        for (int c = 0; c < 3; c++) begin
            n_pa[c] = 24'(i_a[c*CH_W +: CH_W] * i_alpha);
            n_pb[c] = 24'(i_b[c*CH_W +: CH_W] * n_beta);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else begin
            r3_ctl <= i_ctl;
        end
        r3_pa <= n_pa;
        r3_pb <= n_pb;
        r3_a  <= i_a;
        r3_b  <= i_b;
    end

    always_comb begin
        n_blend = '0;
        n_sum   = '0;
        for (int c = 0; c < 3; c++) begin
            n_sum = {1'b0, r3_pa[c]} + {1'b0, r3_pb[c]};
            n_blend[c*CH_W +: CH_W] = n_sum[23:16];
        end
        if (r3_ctl.pass_b) begin
            n_pixel = r3_b;
        end else if (r3_ctl.pass_a) begin
            n_pixel = r3_a;
        end else begin
            n_pixel = n_blend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_ctl.valid;
        end
        r4_pixel <= n_pixel;
    end

    assign o_valid = r4_valid;
    assign o_pixel = r4_pixel;

endmodule
`default_nettype wire

FILE: tb/sv/lkb_blend_checker.sv
// Checker for the luma keyed blend core: predicts each output pixel and compares.
`timescale 1ns / 1ps
module lkb_blend_checker
    import lkb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_busy,
    input  wire t_pixel               i_source_a_pixel,
    input  wire t_pixel               i_source_b_pixel,
    input  wire t_pixel               i_mask_pixel,
    input  wire logic                 i_out_valid,
    input  wire t_pixel               i_out_pixel,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire t_chan                i_cfg_data,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_blended
);

    localparam int unsigned LUMA_R   = 90;
    localparam int unsigned LUMA_G   = 115;
    localparam int unsigned LUMA_B   = 51;
    localparam int unsigned RAMP_MAX = 32'hFF00;
    localparam t_chan       LO_RESET = 8'd120;
    localparam t_chan       HI_RESET = 8'd132;

    t_chan  key_lo = LO_RESET;
    t_chan  key_hi = HI_RESET;
    t_pixel expected_pixels[$];
    int     err_count   = 0;
    int     pend_count  = 0;
    int     check_count = 0;
    int     blend_count = 0;

    assign o_errors  = err_count;
    assign o_pending = pend_count;
    assign o_checked = check_count;
    assign o_blended = blend_count;

    function automatic t_pixel blend_pixel(input t_pixel fg, input t_pixel bg,
                                           input t_pixel key, input t_chan lo,
                                           input t_chan hi, output bit ramped);
        int unsigned luma;
        int unsigned top;
        int unsigned span;
        int unsigned step;
        int unsigned alpha;
        t_pixel      res;
        luma = (key[23:16] * LUMA_R + key[15:8] * LUMA_G + key[7:0] * LUMA_B) >> 8;
        top  = (hi < lo) ? lo : hi;
        span = top - lo;
        if (span < 1) span = 1;
        if (span > 255) span = 255;
        step   = RAMP_MAX / span;
        ramped = 1'b0;
        if (luma < lo) begin
            res = bg;
        end else if (luma >= top) begin
            res = fg;
        end else begin
            ramped = 1'b1;
            alpha  = (luma - lo) * step;
            if (alpha > RAMP_MAX) alpha = RAMP_MAX;
            res = '0;
            for (int ch = 0; ch < 3; ch++) begin
                res[ch*8 +: 8] = 8'((fg[ch*8 +: 8] * alpha
                                     + bg[ch*8 +: 8] * (RAMP_MAX - alpha)) >> 16);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input t_pixel got, input t_pixel want);
        $display("ERROR @%0t: %s: got %08h, expected %08h", $realtime, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        bit     ramped;
        if (!i_rst_n) begin
            key_lo = LO_RESET;
            key_hi = HI_RESET;
            expected_pixels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IDX_START: key_lo = i_cfg_data;
                    CFG_IDX_END:   key_hi = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                want = blend_pixel(i_source_a_pixel, i_source_b_pixel, i_mask_pixel,
                                   key_lo, key_hi, ramped);
                expected_pixels.push_back(want);
                if (ramped) blend_count++;
            end
            if (i_out_valid) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("out_pixel with no beat pending", i_out_pixel, 'x);
                end else begin
                    want = expected_pixels.pop_front();
                    check_count++;
                    if (i_out_pixel !== want) report_mismatch("out_pixel", i_out_pixel, want);
                end
            end
        end
        pend_count <= expected_pixels.size();
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the luma keyed blend testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import lkb_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE       = 8;
    localparam int SEG_ITEMS    = 110;
    localparam int SEGMENTS     = 5;

    logic                 i_clk;
    logic                 i_rst_n          = 1'b0;
    logic                 i_start          = 1'b0;
    t_pixel               i_source_a_pixel = '0;
    t_pixel               i_source_b_pixel = '0;
    t_pixel               i_mask_pixel     = '0;
    logic                 i_cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index      = '0;
    t_chan                i_cfg_data       = '0;
    logic                 o_busy;
    logic                 o_out_valid;
    t_pixel               o_out_pixel;
    logic                 o_cfg_ready;

    int    errors;
    int    pending;
    int    checked;
    int    blended;
    int    cycles   = 0;
    int    idle_pct = 0;
    int    settings = 1;
    t_chan band_lo  = 8'd120;
    t_chan band_hi  = 8'd132;

    luma_keyed_blend_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_source_a_pixel (i_source_a_pixel),
        .i_source_b_pixel (i_source_b_pixel),
        .i_mask_pixel     (i_mask_pixel),
        .o_out_valid      (o_out_valid),
        .o_out_pixel      (o_out_pixel),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    lkb_blend_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_busy           (o_busy),
        .i_source_a_pixel (i_source_a_pixel),
        .i_source_b_pixel (i_source_b_pixel),
        .i_mask_pixel     (i_mask_pixel),
        .i_out_valid      (o_out_valid),
        .i_out_pixel      (o_out_pixel),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_blended        (blended)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d beats still pending", cycles, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_pixel gray(input t_chan level, input t_chan top);
        return {top, level, level, level};
    endfunction

    task automatic send_pixel(input t_pixel fg, input t_pixel bg, input t_pixel key);
        while ($urandom_range(99, 0) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start          <= 1'b1;
        i_source_a_pixel <= fg;
        i_source_b_pixel <= bg;
        i_mask_pixel     <= key;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // hold the pixel channel until every beat has come back
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_chan val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_band(input t_chan lo, input t_chan hi, input bit junk);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (junk) write_reg(CFG_IDX_W'($urandom_range({CFG_IDX_W{1'b1}},
                                                      int'(CFG_IDX_END) + 1)),
                            t_chan'($urandom));
        if ($urandom_range(1, 0)) begin
            write_reg(CFG_IDX_START, lo);
            write_reg(CFG_IDX_END, hi);
        end else begin
            write_reg(CFG_IDX_END, hi);
            write_reg(CFG_IDX_START, lo);
        end
        i_cfg_valid <= 1'b0;
        band_lo = lo;
        band_hi = hi;
        settings++;
    endtask

    task automatic pick_band();
        int    kind;
        t_chan lo;
        t_chan hi;
        kind = $urandom_range(5, 0);
        lo   = t_chan'($urandom);
        hi   = t_chan'($urandom);
        case (kind)
            1: hi = (lo > 8'd240) ? 8'hFF : lo + t_chan'($urandom_range(15, 1));
            2: begin
                lo = $urandom_range(1, 0) ? 8'hFF : 8'h00;
                hi = $urandom_range(1, 0) ? 8'hFF : 8'h00;
            end
            3: if (hi > lo) {lo, hi} = {hi, lo};
            4: hi = lo;
            5: begin
                lo = t_chan'($urandom_range(20, 0));
                hi = t_chan'($urandom_range(255, 230));
            end
            default: ;
        endcase
        set_band(lo, hi, $urandom_range(2, 0) == 0);
    endtask

    function automatic t_pixel rand_source();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_pixel();
        t_chan  top;
        t_chan  g_lo;
        t_chan  g_hi;
        t_pixel key;
        top  = (band_hi < band_lo) ? band_lo : band_hi;
        g_lo = (band_lo > 8'd2) ? band_lo - 8'd2 : 8'd0;
        g_hi = (top < 8'd254) ? top + 8'd1 : 8'hFF;
        case ($urandom_range(9, 0))
            0, 1, 2, 3: key = gray(t_chan'($urandom_range(g_hi, g_lo)), t_chan'($urandom));
            8:          key = {t_chan'($urandom), $urandom_range(1, 0) ? 24'hFFFFFF : 24'h0};
            default:    key = $urandom;
        endcase
        if ($urandom_range(63, 0) == 0) drain();
        send_pixel(rand_source(), rand_source(), key);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset band 120..132
        send_pixel(32'hFFFFFFFF, 32'h00000000, 32'h00000000);
        send_pixel(32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pixel(32'h11223344, 32'h55667788, 32'hFF000000);
        send_pixel(32'hFFFFFFFF, 32'hA5A5A5A5, gray(8'd119, 8'h00));
        send_pixel(32'hFFFFFFFF, 32'hA5A5A5A5, gray(8'd120, 8'hFF));
        send_pixel(32'hFFFFFFFF, 32'h00000000, gray(8'd126, 8'h5A));
        send_pixel(32'hFFFFFFFF, 32'h00000000, gray(8'd131, 8'h00));
        send_pixel(32'hAA55AA55, 32'h00000000, gray(8'd132, 8'h00));
        send_pixel(32'h12345678, 32'h87654321, 32'h00FF0000);
        send_pixel(32'h12345678, 32'h87654321, 32'h0000FF00);
        send_pixel(32'h12345678, 32'h87654321, 32'h000000FF);
        send_pixel(32'h12345678, 32'h87654321, gray(8'd125, 8'hC3));

        // end below start
        set_band(8'd200, 8'd100, 1'b0);
        send_pixel(32'hDEADBEEF, 32'hCAFEF00D, gray(8'd150, 8'h00));
        send_pixel(32'hDEADBEEF, 32'hCAFEF00D, gray(8'd200, 8'h00));
        send_pixel(32'hDEADBEEF, 32'hCAFEF00D, 32'hFFFFFFFF);

        // widest band
        set_band(8'd0, 8'd255, 1'b0);
        send_pixel(32'hFFFFFFFF, 32'h80808080, 32'h00000000);
        send_pixel(32'hFFFFFFFF, 32'h80808080, gray(8'd254, 8'h00));
        send_pixel(32'hFFFFFFFF, 32'h80808080, gray(8'd255, 8'h00));

        // unused index must not disturb the band
        drain();
        repeat (SETTLE) @(posedge i_clk);
        write_reg(CFG_IDX_END + 1'b1, 8'd7);
        write_reg({CFG_IDX_W{1'b1}}, 8'hFF);
        i_cfg_valid <= 1'b0;
        send_pixel(32'h0F0F0F0F, 32'hF0F0F0F0, 32'h00000000);
        send_pixel(32'h0F0F0F0F, 32'hF0F0F0F0, gray(8'd77, 8'h00));

        for (int mode = 0; mode < 3; mode++) begin
            idle_pct = (mode == 0) ? 33 : (mode == 1) ? 65 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                pick_band();
                repeat (SEG_ITEMS) random_pixel();
            end
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);

        $display("Checked %0d output pixels, %0d of them on the blend ramp, over %0d bands",
                 checked, blended, settings);
        $display("Sender paced at 33%% idle, 65%% idle and back to back; unused indexes hit");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/lkb_pkg.sv
src/lkb_recip.sv
src/lkb_key.sv
src/lkb_mix.sv
src/luma_keyed_blend_core.sv
tb/sv/lkb_blend_checker.sv
tb/sv/testbench.sv
